@@ rtl/core/pcbu_pkg.sv @@
package pcbu_pkg;

  // Field widths of the stream items.
  localparam int CoordW = 16;
  localparam int SrcW   = 16;
  localparam int DstW   = 8;
  localparam int ByteW  = 8;
  localparam int NumCh  = 4;
  localparam int AlphaCh = 3;

  // Configuration port.
  localparam int AddrW = 5;
  localparam int DataW = 32;
  localparam int IdxW  = 3;

  // Every 0..1 quantity is an integer over 4096*255. A source channel is
  // scaled by 255, a destination byte by 4096, so both land on that scale.
  localparam int OperW    = 25;
  localparam int ProdW    = 2 * OperW;
  localparam int SumW     = ProdW + 1;
  localparam int DstShift = 12;

  localparam logic signed [OperW-1:0] UnitScale = 25'sd1044480;
  localparam logic signed [OperW-1:0] Scale255  = 25'sd255;

  // The full product scale is 65025 * 2^24. Dropping the low 24 bits leaves a
  // value of at most 65025, which is then divided by 255.
  localparam int TermFracW = 24;
  localparam int TermTopW  = 16;
  localparam int QSumW     = TermTopW + 1;
  localparam logic [TermTopW-1:0] TermTop = 16'd65025;
  localparam logic signed [SumW-1:0] TermScale =
      $signed(SumW'({TermTop, {TermFracW{1'b0}}}));

  typedef enum logic [3:0] {
    FacZero      = 4'd0,
    FacOne       = 4'd1,
    FacSrcCol    = 4'd2,
    FacInvSrcCol = 4'd3,
    FacDstCol    = 4'd4,
    FacInvDstCol = 4'd5,
    FacSrcA      = 4'd6,
    FacInvSrcA   = 4'd7,
    FacDstA      = 4'd8,
    FacInvDstA   = 4'd9,
    FacSat       = 4'd10
  } factor_e;

  typedef enum logic [2:0] {
    OpAdd  = 3'd0,
    OpSub  = 3'd1,
    OpRsub = 3'd2,
    OpMin  = 3'd3,
    OpMax  = 3'd4
  } op_e;

  typedef enum logic [IdxW-1:0] {
    RegEnable     = 3'd0,
    RegColorOp    = 3'd1,
    RegAlphaOp    = 3'd2,
    RegSrcColorF  = 3'd3,
    RegDstColorF  = 3'd4,
    RegSrcAlphaF  = 3'd5,
    RegDstAlphaF  = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic       enable;
    logic [2:0] cop;
    logic [2:0] aop;
    logic [3:0] scf;
    logic [3:0] dcf;
    logic [3:0] saf;
    logic [3:0] daf;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    enable: 1'b0,
    cop:    OpAdd,
    aop:    OpAdd,
    scf:    FacOne,
    dcf:    FacZero,
    saf:    FacOne,
    daf:    FacZero
  };

  // One channel after factor selection.
  typedef struct packed {
    logic signed [OperW-1:0] s;
    logic signed [OperW-1:0] d;
    logic signed [OperW-1:0] sf;
    logic signed [OperW-1:0] df;
    logic [2:0]              op;
  } lane_t;

  // Load enables of the stages behind factor selection.
  typedef struct packed {
    logic mul;
    logic op;
    logic out;
  } stage_en_t;

endpackage

@@ rtl/core/pcbu_cfg_regs.sv @@
module pcbu_cfg_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pcbu_pkg::AddrW-1:0]  paddr,
  input  logic [pcbu_pkg::DataW-1:0]  pwdata,
  output logic [pcbu_pkg::DataW-1:0]  prdata,
  output logic                        pready,
  output pcbu_pkg::cfg_t              cfg_o
);

  pcbu_pkg::cfg_t cfg_d, cfg_q;
  logic [pcbu_pkg::IdxW-1:0] idx;
  logic wr_en;

  assign idx    = paddr[pcbu_pkg::AddrW-1:2];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        pcbu_pkg::RegEnable:    cfg_d.enable = pwdata[0];
        pcbu_pkg::RegColorOp:   cfg_d.cop    = pwdata[2:0];
        pcbu_pkg::RegAlphaOp:   cfg_d.aop    = pwdata[2:0];
        pcbu_pkg::RegSrcColorF: cfg_d.scf    = pwdata[3:0];
        pcbu_pkg::RegDstColorF: cfg_d.dcf    = pwdata[3:0];
        pcbu_pkg::RegSrcAlphaF: cfg_d.saf    = pwdata[3:0];
        pcbu_pkg::RegDstAlphaF: cfg_d.daf    = pwdata[3:0];
        default:                cfg_d        = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      pcbu_pkg::RegEnable:    prdata = pcbu_pkg::DataW'(cfg_q.enable);
      pcbu_pkg::RegColorOp:   prdata = pcbu_pkg::DataW'(cfg_q.cop);
      pcbu_pkg::RegAlphaOp:   prdata = pcbu_pkg::DataW'(cfg_q.aop);
      pcbu_pkg::RegSrcColorF: prdata = pcbu_pkg::DataW'(cfg_q.scf);
      pcbu_pkg::RegDstColorF: prdata = pcbu_pkg::DataW'(cfg_q.dcf);
      pcbu_pkg::RegSrcAlphaF: prdata = pcbu_pkg::DataW'(cfg_q.saf);
      pcbu_pkg::RegDstAlphaF: prdata = pcbu_pkg::DataW'(cfg_q.daf);
      default:                prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= pcbu_pkg::CfgReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

@@ rtl/core/pcbu_factor_sel.sv @@
module pcbu_factor_sel (
  input  logic                                 clk_i,
  input  logic                                 en_i,
  input  pcbu_pkg::cfg_t                       cfg_i,
  input  logic signed [pcbu_pkg::SrcW-1:0]     src_i [pcbu_pkg::NumCh],
  input  logic        [pcbu_pkg::DstW-1:0]     dst_i [pcbu_pkg::NumCh],
  output pcbu_pkg::lane_t                      lane_o [pcbu_pkg::NumCh]
);

  logic signed [pcbu_pkg::OperW-1:0] s_c [pcbu_pkg::NumCh];
  logic signed [pcbu_pkg::OperW-1:0] d_c [pcbu_pkg::NumCh];
  pcbu_pkg::lane_t lane_d [pcbu_pkg::NumCh];
  pcbu_pkg::lane_t lane_q [pcbu_pkg::NumCh];

  function automatic logic signed [pcbu_pkg::OperW-1:0] pick(
    input logic [3:0]                        kind,
    input logic                              is_alpha,
    input logic signed [pcbu_pkg::OperW-1:0] s_ch,
    input logic signed [pcbu_pkg::OperW-1:0] d_ch,
    input logic signed [pcbu_pkg::OperW-1:0] s_a,
    input logic signed [pcbu_pkg::OperW-1:0] d_a
  );
    logic signed [pcbu_pkg::OperW-1:0] inv_da;
    logic signed [pcbu_pkg::OperW-1:0] sat;
    inv_da = pcbu_pkg::UnitScale - d_a;
    sat    = (s_a < inv_da) ? s_a : inv_da;
    case (kind)
      pcbu_pkg::FacOne:       pick = pcbu_pkg::UnitScale;
      pcbu_pkg::FacSrcCol:    pick = s_ch;
      pcbu_pkg::FacInvSrcCol: pick = pcbu_pkg::UnitScale - s_ch;
      pcbu_pkg::FacDstCol:    pick = d_ch;
      pcbu_pkg::FacInvDstCol: pick = pcbu_pkg::UnitScale - d_ch;
      pcbu_pkg::FacSrcA:      pick = s_a;
      pcbu_pkg::FacInvSrcA:   pick = pcbu_pkg::UnitScale - s_a;
      pcbu_pkg::FacDstA:      pick = d_a;
      pcbu_pkg::FacInvDstA:   pick = inv_da;
      // Alpha saturate leaves the alpha channel at full weight.
      pcbu_pkg::FacSat:       pick = is_alpha ? pcbu_pkg::UnitScale : sat;
      default:                pick = '0;
    endcase
  endfunction

  always_comb begin
    for (int ch = 0; ch < pcbu_pkg::NumCh; ch++) begin
      s_c[ch] = pcbu_pkg::OperW'(src_i[ch]) * pcbu_pkg::Scale255;
      d_c[ch] = pcbu_pkg::OperW'({dst_i[ch], {pcbu_pkg::DstShift{1'b0}}});
    end
  end

  always_comb begin
    for (int ch = 0; ch < pcbu_pkg::NumCh; ch++) begin
      lane_d[ch].s = s_c[ch];
      lane_d[ch].d = d_c[ch];
      if (!cfg_i.enable) begin
        // Pass-through is the same as one times source plus zero.
        lane_d[ch].sf = pcbu_pkg::UnitScale;
        lane_d[ch].df = '0;
        lane_d[ch].op = pcbu_pkg::OpAdd;
      end else if (ch == pcbu_pkg::AlphaCh) begin
        lane_d[ch].sf = pick(cfg_i.saf, 1'b1, s_c[ch], d_c[ch],
                             s_c[pcbu_pkg::AlphaCh], d_c[pcbu_pkg::AlphaCh]);
        lane_d[ch].df = pick(cfg_i.daf, 1'b1, s_c[ch], d_c[ch],
                             s_c[pcbu_pkg::AlphaCh], d_c[pcbu_pkg::AlphaCh]);
        lane_d[ch].op = cfg_i.aop;
      end else begin
        lane_d[ch].sf = pick(cfg_i.scf, 1'b0, s_c[ch], d_c[ch],
                             s_c[pcbu_pkg::AlphaCh], d_c[pcbu_pkg::AlphaCh]);
        lane_d[ch].df = pick(cfg_i.dcf, 1'b0, s_c[ch], d_c[ch],
                             s_c[pcbu_pkg::AlphaCh], d_c[pcbu_pkg::AlphaCh]);
        lane_d[ch].op = cfg_i.cop;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_q <= lane_d;
    end
  end

  assign lane_o = lane_q;

endmodule

@@ rtl/core/pcbu_blend_lane.sv @@
module pcbu_blend_lane (
  input  logic                        clk_i,
  input  pcbu_pkg::stage_en_t         en_i,
  input  pcbu_pkg::lane_t             lane_i,
  output logic [pcbu_pkg::ByteW-1:0]  pix_o
);

  logic signed [pcbu_pkg::ProdW-1:0] a_d, a_q;
  logic signed [pcbu_pkg::ProdW-1:0] b_d, b_q;
  logic [2:0]                        op_q;
  logic signed [pcbu_pkg::SumW-1:0]  a_x, b_x;
  logic signed [pcbu_pkg::SumW-1:0]  v_d, v_q;
  logic [pcbu_pkg::TermTopW-1:0]     top_c;
  logic [pcbu_pkg::QSumW-1:0]        qsum_c;
  logic [pcbu_pkg::ByteW-1:0]        pix_d, pix_q;

  // Multiply stage: source and destination terms.
  assign a_d = pcbu_pkg::ProdW'(lane_i.s) * pcbu_pkg::ProdW'(lane_i.sf);
  assign b_d = pcbu_pkg::ProdW'(lane_i.d) * pcbu_pkg::ProdW'(lane_i.df);

  // Operation stage.
  assign a_x = pcbu_pkg::SumW'(a_q);
  assign b_x = pcbu_pkg::SumW'(b_q);

  always_comb begin
    case (op_q)
      pcbu_pkg::OpSub:  v_d = a_x - b_x;
      pcbu_pkg::OpRsub: v_d = b_x - a_x;
      pcbu_pkg::OpMin:  v_d = (a_x < b_x) ? a_x : b_x;
      pcbu_pkg::OpMax:  v_d = (a_x > b_x) ? a_x : b_x;
      default:          v_d = a_x + b_x;
    endcase
  end

  // Output stage: clamp to 0..1, keep the top bits, then divide by 255 with
  // the usual add-high-byte correction, exact for values up to 255*255.
  always_comb begin
    if (v_q < 0) begin
      top_c = '0;
    end else if (v_q > pcbu_pkg::TermScale) begin
      top_c = pcbu_pkg::TermTop;
    end else begin
      top_c = v_q[pcbu_pkg::TermFracW +: pcbu_pkg::TermTopW];
    end
    qsum_c = pcbu_pkg::QSumW'(top_c)
           + pcbu_pkg::QSumW'(top_c[pcbu_pkg::TermTopW-1:pcbu_pkg::ByteW])
           + pcbu_pkg::QSumW'(1);
    pix_d  = qsum_c[pcbu_pkg::ByteW +: pcbu_pkg::ByteW];
  end

  always_ff @(posedge clk_i) begin
    if (en_i.mul) begin
      a_q  <= a_d;
      b_q  <= b_d;
      op_q <= lane_i.op;
    end
    if (en_i.op) begin
      v_q <= v_d;
    end
    if (en_i.out) begin
      pix_q <= pix_d;
    end
  end

  assign pix_o = pix_q;

endmodule

@@ rtl/core/pixel_color_blend_unit.sv @@
// Throughput: one item per cycle while results are taken at the output;
// stages are factor select, 25x25 multiply, blend operation, and clamp with
// scale to bytes, each behind its own register.
// Reset clears the stage valid bits and loads the configuration defaults
// (blending off, add, source factors one, destination factors zero).
module pixel_color_blend_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Input item.
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // Fields from bit 0 up: pixel_x[15:0], pixel_y[31:16], src_red[47:32],
  // src_green[63:48], src_blue[79:64], src_opacity[95:80], dst_red[103:96],
  // dst_green[111:104], dst_blue[119:112], dst_opacity[127:120].
  input  logic [127:0]                 s_axis_tdata,
  // Result item.
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // Fields from bit 0 up: out_x[15:0], out_y[31:16], out_red[39:32],
  // out_green[47:40], out_blue[55:48], out_alpha[63:56].
  output logic [63:0]                  m_axis_tdata,
  // Configuration registers.
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pcbu_pkg::AddrW-1:0]   paddr,
  input  logic [pcbu_pkg::DataW-1:0]   pwdata,
  output logic [pcbu_pkg::DataW-1:0]   prdata,
  output logic                         pready
);

  localparam int Stages = 4;
  localparam int XyW    = 2 * pcbu_pkg::CoordW;

  pcbu_pkg::cfg_t cfg;

  pcbu_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Each stage holds a valid bit and takes a new item when it is empty or
  // when the stage behind it takes its item, so bubbles close up and the
  // input keeps moving while a result waits, as long as some stage is empty.
  logic [Stages-1:0] valid_d, valid_q;
  logic [Stages-1:0] stage_ready;
  logic [Stages-1:0] prev_valid;

  assign prev_valid = {valid_q[Stages-2:0], s_axis_tvalid};

  always_comb begin
    stage_ready[Stages-1] = !valid_q[Stages-1] || m_axis_tready;
    for (int k = Stages - 2; k >= 0; k--) begin
      stage_ready[k] = !valid_q[k] || stage_ready[k+1];
    end
    for (int k = 0; k < Stages; k++) begin
      valid_d[k] = stage_ready[k] ? prev_valid[k] : valid_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign s_axis_tready = stage_ready[0];
  assign m_axis_tvalid = valid_q[Stages-1];

  // Unpack the input item.
  logic signed [pcbu_pkg::SrcW-1:0] src [pcbu_pkg::NumCh];
  logic        [pcbu_pkg::DstW-1:0] dst [pcbu_pkg::NumCh];

  always_comb begin
    for (int ch = 0; ch < pcbu_pkg::NumCh; ch++) begin
      src[ch] = s_axis_tdata[XyW + ch*pcbu_pkg::SrcW +: pcbu_pkg::SrcW];
      dst[ch] = s_axis_tdata[XyW + pcbu_pkg::NumCh*pcbu_pkg::SrcW
                             + ch*pcbu_pkg::DstW +: pcbu_pkg::DstW];
    end
  end

  // The coordinate travels alongside the color stages.
  logic [XyW-1:0] xy_q [Stages];

  always_ff @(posedge clk_i) begin
    if (stage_ready[0]) begin
      xy_q[0] <= s_axis_tdata[XyW-1:0];
    end
    for (int k = 1; k < Stages; k++) begin
      if (stage_ready[k]) begin
        xy_q[k] <= xy_q[k-1];
      end
    end
  end

  pcbu_pkg::lane_t lane [pcbu_pkg::NumCh];

  pcbu_factor_sel u_factor (
    .clk_i  (clk_i),
    .en_i   (stage_ready[0]),
    .cfg_i  (cfg),
    .src_i  (src),
    .dst_i  (dst),
    .lane_o (lane)
  );

  pcbu_pkg::stage_en_t lane_en;

  assign lane_en.mul = stage_ready[1];
  assign lane_en.op  = stage_ready[2];
  assign lane_en.out = stage_ready[3];

  logic [pcbu_pkg::ByteW-1:0] pix [pcbu_pkg::NumCh];

  for (genvar ch = 0; ch < pcbu_pkg::NumCh; ch++) begin : g_lane
    pcbu_blend_lane u_lane (
      .clk_i  (clk_i),
      .en_i   (lane_en),
      .lane_i (lane[ch]),
      .pix_o  (pix[ch])
    );
  end

  assign m_axis_tdata = {pix[3], pix[2], pix[1], pix[0], xy_q[Stages-1]};

endmodule

@@ sim/pcbu_blend_checker.sv @@
`timescale 1ns / 1ps

module pcbu_blend_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_tvalid_i,
  input  logic                       in_tready_i,
  input  logic [127:0]               in_tdata_i,
  input  logic                       out_tvalid_i,
  input  logic                       out_tready_i,
  input  logic [63:0]                out_tdata_i,
  input  logic                       psel_i,
  input  logic                       penable_i,
  input  logic                       pwrite_i,
  input  logic [pcbu_pkg::AddrW-1:0] paddr_i,
  input  logic [pcbu_pkg::DataW-1:0] pwdata_i,
  input  logic                       pready_i,
  output int                         fault_count_o,
  output int                         pending_o
);

  // A 0..1 quantity is an integer over 4096*255; a product of two is over its square.
  localparam longint UnitQ = 64'sd1044480;
  localparam longint TermQ = UnitQ * UnitQ;

  // Same layout as the result item: x in the lowest bits, then y, then red up to alpha.
  typedef struct packed {
    logic [3:0][7:0] rgba;
    logic [15:0]     y;
    logic [15:0]     x;
  } pixel_out_t;

  pcbu_pkg::cfg_t blend_cfg;
  pixel_out_t     expected_pixels[$];
  int             faults = 0;

  function automatic logic [7:0] to_byte(input longint v, input longint scale);
    longint c;
    c = (v < 0) ? 64'sd0 : ((v > scale) ? scale : v);
    return 8'(c * 255 / scale);
  endfunction

  function automatic pixel_out_t blend_fragment(input logic [127:0] item,
                                                input pcbu_pkg::cfg_t c);
    pixel_out_t px;
    longint     s [4];
    longint     d [4];
    longint     term [2];
    longint     f;
    longint     v;
    logic [3:0] kind;
    logic [2:0] op;
    bit         is_alpha;
    int         ch;
    int         t;
    px.x = item[15:0];
    px.y = item[31:16];
    for (ch = 0; ch < pcbu_pkg::NumCh; ch++) begin
      s[ch] = longint'($signed(item[32+16*ch +: 16])) * 255;
      d[ch] = longint'(item[96+8*ch +: 8]) * 4096;
    end
    for (ch = 0; ch < pcbu_pkg::NumCh; ch++) begin
      if (!c.enable) begin
        px.rgba[ch] = to_byte(s[ch], UnitQ);
      end else begin
        is_alpha = (ch == pcbu_pkg::AlphaCh);
        op = is_alpha ? c.aop : c.cop;
        for (t = 0; t < 2; t++) begin
          if (t == 0) begin
            kind = is_alpha ? c.saf : c.scf;
          end else begin
            kind = is_alpha ? c.daf : c.dcf;
          end
          case (kind)
            pcbu_pkg::FacOne:       f = UnitQ;
            pcbu_pkg::FacSrcCol:    f = s[ch];
            pcbu_pkg::FacInvSrcCol: f = UnitQ - s[ch];
            pcbu_pkg::FacDstCol:    f = d[ch];
            pcbu_pkg::FacInvDstCol: f = UnitQ - d[ch];
            pcbu_pkg::FacSrcA:      f = s[pcbu_pkg::AlphaCh];
            pcbu_pkg::FacInvSrcA:   f = UnitQ - s[pcbu_pkg::AlphaCh];
            pcbu_pkg::FacDstA:      f = d[pcbu_pkg::AlphaCh];
            pcbu_pkg::FacInvDstA:   f = UnitQ - d[pcbu_pkg::AlphaCh];
            // Alpha saturate is one on the alpha channel itself.
            pcbu_pkg::FacSat: begin
              if (is_alpha) begin
                f = UnitQ;
              end else begin
                f = (s[pcbu_pkg::AlphaCh] < UnitQ - d[pcbu_pkg::AlphaCh]) ?
                    s[pcbu_pkg::AlphaCh] : UnitQ - d[pcbu_pkg::AlphaCh];
              end
            end
            // Zero and the unused codes.
            default:      f = 0;
          endcase
          term[t] = ((t == 0) ? s[ch] : d[ch]) * f;
        end
        case (op)
          pcbu_pkg::OpSub:   v = term[0] - term[1];
          pcbu_pkg::OpRsub:  v = term[1] - term[0];
          pcbu_pkg::OpMin:   v = (term[0] < term[1]) ? term[0] : term[1];
          pcbu_pkg::OpMax:   v = (term[0] > term[1]) ? term[0] : term[1];
          default:           v = term[0] + term[1];
        endcase
        px.rgba[ch] = to_byte(v, TermQ);
      end
    end
    return px;
  endfunction

  task automatic compare_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      faults++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pixel_out_t want;
    pixel_out_t got;
    if (!rst_ni) begin
      blend_cfg = pcbu_pkg::CfgReset;
      expected_pixels.delete();
      fault_count_o <= faults;
      pending_o <= 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[pcbu_pkg::AddrW-1:2])
          pcbu_pkg::RegEnable:    blend_cfg.enable = pwdata_i[0];
          pcbu_pkg::RegColorOp:   blend_cfg.cop = pwdata_i[2:0];
          pcbu_pkg::RegAlphaOp:   blend_cfg.aop = pwdata_i[2:0];
          pcbu_pkg::RegSrcColorF: blend_cfg.scf = pwdata_i[3:0];
          pcbu_pkg::RegDstColorF: blend_cfg.dcf = pwdata_i[3:0];
          pcbu_pkg::RegSrcAlphaF: blend_cfg.saf = pwdata_i[3:0];
          pcbu_pkg::RegDstAlphaF: blend_cfg.daf = pwdata_i[3:0];
          default: ;
        endcase
      end
      if (in_tvalid_i && in_tready_i) begin
        expected_pixels.push_back(blend_fragment(in_tdata_i, blend_cfg));
      end
      if (out_tvalid_i && out_tready_i) begin
        got = pixel_out_t'(out_tdata_i);
        if (expected_pixels.size() == 0) begin
          $display("%0t: result item with none expected, actual %h", $time, out_tdata_i);
          faults++;
        end else begin
          want = expected_pixels.pop_front();
          compare_field("out_x", want.x, got.x);
          compare_field("out_y", want.y, got.y);
          compare_field("out_red", want.rgba[0], got.rgba[0]);
          compare_field("out_green", want.rgba[1], got.rgba[1]);
          compare_field("out_blue", want.rgba[2], got.rgba[2]);
          compare_field("out_alpha", want.rgba[3], got.rgba[3]);
        end
      end
      fault_count_o <= faults;
      pending_o <= expected_pixels.size();
    end
  end

endmodule

@@ sim/tb_pixel_color_blend_unit.sv @@
`timescale 1ns / 1ps

// Top of the blend unit testbench. This module only makes stimulus and gives
// the verdict; the checker beside the block watches both stream channels and
// the register port, predicts every result item and compares it.
module tb_pixel_color_blend_unit;

  localparam int Latency = 3;
  // One past the last register. The block must drop writes to it.
  localparam int SpareRegIdx = 7;
  localparam int CycleLimit = 400000;
  localparam int RandomPhases = 28;
  localparam int PhaseItems = 50;
  // In this phase the receiver stops for a long stretch while items keep coming.
  localparam int HoldPhase = 20;
  localparam int HoldCycles = 300;

  // Input item layout: x in the lowest bits, then y, the four source channels
  // (red first) and the four destination bytes (red first).
  typedef struct packed {
    logic [3:0][7:0]  dst;
    logic [3:0][15:0] src;
    logic [15:0]      y;
    logic [15:0]      x;
  } fragment_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       s_axis_tvalid = 1'b0;
  logic                       s_axis_tready;
  logic [127:0]               s_axis_tdata = '0;
  logic                       m_axis_tvalid;
  logic                       m_axis_tready = 1'b0;
  logic [63:0]                m_axis_tdata;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [pcbu_pkg::AddrW-1:0] paddr = '0;
  logic [pcbu_pkg::DataW-1:0] pwdata = '0;
  logic [pcbu_pkg::DataW-1:0] prdata;
  logic                       pready;

  int fault_count;
  int pending;
  int cycle_count = 0;
  // Percent of cycles in which the sender and the receiver hold back.
  int src_idle_pct = 20;
  int dst_idle_pct = 82;
  logic hold_req = 1'b0;
  logic hold_taken = 1'b0;
  int hold_left = 0;

  pixel_color_blend_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  pcbu_blend_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_tvalid_i   (s_axis_tvalid),
    .in_tready_i   (s_axis_tready),
    .in_tdata_i    (s_axis_tdata),
    .out_tvalid_i  (m_axis_tvalid),
    .out_tready_i  (m_axis_tready),
    .out_tdata_i   (m_axis_tdata),
    .psel_i        (psel),
    .penable_i     (penable),
    .pwrite_i      (pwrite),
    .paddr_i       (paddr),
    .pwdata_i      (pwdata),
    .pready_i      (pready),
    .fault_count_o (fault_count),
    .pending_o     (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog. A hung handshake or a result that never arrives ends up here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Receiver side. A long hold, once requested, overrides the random stalls so
  // that the pipeline fills up and the block has to stall its input.
  always @(posedge clk_i) begin
    if (hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left <= HoldCycles;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= dst_idle_pct);
    end
  end

  // A register write: setup phase, access phase, then an idle phase so that
  // back-to-back writes never raise psel in the step that lowers it. Bits
  // above the register's width carry junk, which the block must ignore.
  task automatic apb_write(input int idx, input logic [31:0] val, input int fieldw);
    logic [31:0] mask;
    mask = (32'd1 << fieldw) - 32'd1;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= pcbu_pkg::AddrW'(4 * idx);
    pwdata <= (32'($urandom) & ~mask) | (val & mask);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apply_blend(input logic en, input logic [2:0] cop, input logic [2:0] aop,
                             input logic [3:0] scf, input logic [3:0] dcf,
                             input logic [3:0] saf, input logic [3:0] daf);
    apb_write(pcbu_pkg::RegEnable, 32'(en), 1);
    apb_write(pcbu_pkg::RegColorOp, 32'(cop), 3);
    apb_write(pcbu_pkg::RegAlphaOp, 32'(aop), 3);
    apb_write(pcbu_pkg::RegSrcColorF, 32'(scf), 4);
    apb_write(pcbu_pkg::RegDstColorF, 32'(dcf), 4);
    apb_write(pcbu_pkg::RegSrcAlphaF, 32'(saf), 4);
    apb_write(pcbu_pkg::RegDstAlphaF, 32'(daf), 4);
  endtask

  // Offers one item and returns in the step of the edge that accepts it.
  task automatic send_fragment(input fragment_t f);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= f;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Stops sending and waits until every expected result has come back and
  // then past the pipeline depth, so the block is idle afterwards.
  // The first edge lets the checker count the item accepted just before.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (Latency + 4) @(posedge clk_i);
  endtask

  // Source channel: mostly inside 0..1, often right around 1.0 or at the
  // ends of the 16-bit range, otherwise anything (half of it negative).
  function automatic logic [15:0] rand_src();
    case ($urandom_range(9))
      0, 1, 2, 3, 4: return 16'($urandom_range(0, 4096));
      5:             return 16'($urandom_range(4090, 4100));
      6:             return $urandom_range(1) ? 16'h7FFF : 16'h8000;
      default:       return 16'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] rand_dst();
    if ($urandom_range(3) == 0) begin
      return $urandom_range(1) ? 8'hFF : 8'h00;
    end
    return 8'($urandom);
  endfunction

  function automatic fragment_t random_fragment();
    fragment_t f;
    int ch;
    f.x = 16'($urandom);
    f.y = 16'($urandom);
    for (ch = 0; ch < pcbu_pkg::NumCh; ch++) begin
      f.src[ch] = rand_src();
      f.dst[ch] = rand_dst();
    end
    return f;
  endfunction

  // Mostly the defined codes, now and then one of the unused ones.
  function automatic logic [3:0] rand_factor();
    if ($urandom_range(7) == 0) begin
      return 4'($urandom_range(11, 15));
    end
    return 4'($urandom_range(0, 10));
  endfunction

  function automatic logic [2:0] rand_op();
    if ($urandom_range(5) == 0) begin
      return 3'($urandom_range(5, 7));
    end
    return 3'($urandom_range(0, 4));
  endfunction

  initial begin
    fragment_t f;
    int k;
    int phase;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // A write past the last register must leave the reset configuration alone.
    apb_write(SpareRegIdx, 32'($urandom), 32);

    // Blending off after reset: the clamped source goes straight out and the
    // destination bytes play no part.
    f = random_fragment();
    f.x = 16'h0000;
    f.y = 16'h0000;
    f.src = {4{16'h8000}};
    f.dst = {4{8'hFF}};
    send_fragment(f);
    f.x = 16'hFFFF;
    f.y = 16'hFFFF;
    f.src = {4{16'h7FFF}};
    f.dst = {4{8'h00}};
    send_fragment(f);
    f = random_fragment();
    f.src = {16'd0, 16'd4097, 16'd4095, 16'd4096};
    send_fragment(f);
    f = random_fragment();
    f.src = {16'hF000, 16'd2048, 16'd1, 16'hFFFF};
    send_fragment(f);
    send_fragment(random_fragment());
    send_fragment(random_fragment());
    drain();

    // Blending on, walking every operation code (the unused ones act as add)
    // and every factor code, alpha saturate and color factors used on alpha
    // among them.
    for (k = 0; k < 8; k++) begin
      apply_blend(1'b1, 3'(k), 3'(7 - k), 4'(k), 4'(k + 8), 4'(k + 10), 4'(k + 3));
      f = random_fragment();
      f.src[0] = 16'h1000;
      f.src[1] = 16'h7FFF;
      f.src[2] = 16'h8000;
      f.dst[0] = 8'hFF;
      f.dst[1] = 8'h00;
      send_fragment(f);
      send_fragment(random_fragment());
      drain();
    end

    // Random part. Each phase gets its own configuration, written while the
    // block is idle. Idling goes from a slow receiver to a slow sender to
    // none at all.
    for (phase = 0; phase < RandomPhases; phase++) begin
      if (phase < RandomPhases / 3) begin
        src_idle_pct = 20;
        dst_idle_pct <= 82;
      end else if (phase < 2 * RandomPhases / 3) begin
        src_idle_pct = 82;
        dst_idle_pct <= 20;
      end else begin
        src_idle_pct = 0;
        dst_idle_pct <= 0;
      end
      case (phase)
        // Back to plain pass-through with random factors still in place.
        0: apply_blend(1'b0, rand_op(), rand_op(), rand_factor(), rand_factor(),
                       rand_factor(), rand_factor());
        1: apply_blend(1'b1, pcbu_pkg::OpAdd, pcbu_pkg::OpAdd, pcbu_pkg::FacZero,
                       pcbu_pkg::FacZero, pcbu_pkg::FacZero, pcbu_pkg::FacZero);
        2: apply_blend(1'b1, 3'h7, 3'h7, 4'hF, 4'hF, 4'hF, 4'hF);
        default: apply_blend($urandom_range(9) != 0, rand_op(), rand_op(), rand_factor(),
                             rand_factor(), rand_factor(), rand_factor());
      endcase
      if (phase == HoldPhase) begin
        hold_req <= 1'b1;
      end
      repeat (PhaseItems) send_fragment(random_fragment());
      drain();
    end

    if (fault_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
